### rtl/core/bcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types, codes and constants of the button click classifier.
// ----------------------------------------------------------------------------
package bcc_pkg;

	localparam int TIME_W   = 48;
	localparam int MS_W     = 16;
	localparam int THR_W    = 26;   // 65535 ms * 1000 us fits in 26 bits
	localparam int CFG_IDX_W = 3;
	localparam int ACT_W    = 3;
	localparam int CLK_W    = 2;

	localparam logic [THR_W-1:0] US_PER_MS = THR_W'(1000);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 3'd4;

	// register reset values in milliseconds
	localparam logic [MS_W-1:0] RST_DEBOUNCE_MS = 16'd20;
	localparam logic [MS_W-1:0] RST_SHORT_MS    = 16'd450;
	localparam logic [MS_W-1:0] RST_DOUBLE_MS   = 16'd300;
	localparam logic [MS_W-1:0] RST_LONG_MS     = 16'd800;
	localparam logic [MS_W-1:0] RST_HOLD_MS     = 16'd10000;

	// action codes
	localparam logic [ACT_W-1:0] ACT_NONE   = 3'd0;
	localparam logic [ACT_W-1:0] ACT_SINGLE = 3'd1;
	localparam logic [ACT_W-1:0] ACT_DOUBLE = 3'd2;
	localparam logic [ACT_W-1:0] ACT_LONG   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_RESET  = 3'd4;

	// operation codes
	localparam logic OP_EDGE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef struct packed {
		logic              op;
		logic              pin;
		logic [TIME_W-1:0] time_us;
	} bcc_item_t;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic             edge_accepted;
		logic             is_down;
		logic             last_result;
	} bcc_result_t;

	// thresholds held in microseconds
	typedef struct packed {
		logic [THR_W-1:0] debounce;
		logic [THR_W-1:0] short_click;
		logic [THR_W-1:0] double_click;
		logic [THR_W-1:0] long_press;
		logic [THR_W-1:0] reset_hold;
	} bcc_thresh_t;

	typedef struct packed {
		logic valid;   // result register holds a request
		logic pend;    // second result waits behind it
		logic free;    // result register takes a new item this cycle
	} bcc_out_status_t;

	function automatic logic [THR_W-1:0] ms_to_us(input logic [MS_W-1:0] ms);
		ms_to_us = THR_W'(ms) * US_PER_MS;
	endfunction

endpackage

### rtl/core/bcc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_cfg_regs
// Timing registers; each write is scaled to microseconds as it is stored.
// ----------------------------------------------------------------------------
module bcc_cfg_regs
	import bcc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [MS_W-1:0]      wr_data,
	output bcc_thresh_t          thresh
);

	bcc_thresh_t      thresh_q;
	logic [THR_W-1:0] wr_us;

	assign wr_us  = ms_to_us(wr_data);
	assign thresh = thresh_q;

	// store the selected register; drop writes past the last index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q.debounce     <= ms_to_us(RST_DEBOUNCE_MS);
			thresh_q.short_click  <= ms_to_us(RST_SHORT_MS);
			thresh_q.double_click <= ms_to_us(RST_DOUBLE_MS);
			thresh_q.long_press   <= ms_to_us(RST_LONG_MS);
			thresh_q.reset_hold   <= ms_to_us(RST_HOLD_MS);
		end else if (wr_en) begin
			case (wr_index)
				CFG_DEBOUNCE: thresh_q.debounce     <= wr_us;
				CFG_SHORT:    thresh_q.short_click  <= wr_us;
				CFG_DOUBLE:   thresh_q.double_click <= wr_us;
				CFG_LONG:     thresh_q.long_press   <= wr_us;
				CFG_HOLD:     thresh_q.reset_hold   <= wr_us;
				default: ;
			endcase
		end
	end

endmodule

### rtl/core/bcc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_core
// Debounce and click state with the classification logic of one item.
// ----------------------------------------------------------------------------
module bcc_core
	import bcc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  bcc_item_t   item,
	input  bcc_thresh_t thresh,
	output bcc_result_t res0,
	output bcc_result_t res1,
	output logic        two
);

	logic              down_q, press_armed_q, release_armed_q, long_done_q, hold_done_q;
	logic [CLK_W-1:0]  clicks_q;
	logic [TIME_W-1:0] last_edge_q, press_start_q, release_time_q;

	logic              down_d, press_armed_d, release_armed_d, long_done_d, hold_done_d;
	logic [CLK_W-1:0]  clicks_d, clicks_inc;
	logic [TIME_W-1:0] last_edge_d, press_start_d, release_time_d;

	logic [TIME_W-1:0] el_edge, el_press, el_rel;
	logic              pressed, bounce, short_press;
	logic              fire_long, fire_hold, fire_single;

	// elapsed times wrap modulo 2^48
	assign el_edge  = item.time_us - last_edge_q;
	assign el_press = item.time_us - press_start_q;
	assign el_rel   = item.time_us - release_time_q;

	assign pressed     = ~item.pin;
	assign bounce      = el_edge < TIME_W'(thresh.debounce);
	assign short_press = el_press < TIME_W'(thresh.short_click);
	assign clicks_inc  = (clicks_q == 2'd3) ? clicks_q : clicks_q + 2'd1;

	assign fire_long   = down_q && press_armed_q && !long_done_q &&
		(el_press >= TIME_W'(thresh.long_press));
	assign fire_hold   = down_q && press_armed_q && !hold_done_q &&
		(el_press >= TIME_W'(thresh.reset_hold));
	assign fire_single = !down_q && (clicks_q == 2'd1) && release_armed_q &&
		(el_rel >= TIME_W'(thresh.double_click));

	// next state and results
	always_comb begin
		down_d          = down_q;
		press_armed_d   = press_armed_q;
		release_armed_d = release_armed_q;
		long_done_d     = long_done_q;
		hold_done_d     = hold_done_q;
		clicks_d        = clicks_q;
		last_edge_d     = last_edge_q;
		press_start_d   = press_start_q;
		release_time_d  = release_time_q;

		res0.action        = ACT_NONE;
		res0.edge_accepted = 1'b0;
		res0.is_down       = down_q;
		res0.last_result   = 1'b1;
		res1.action        = ACT_RESET;
		res1.edge_accepted = 1'b0;
		res1.is_down       = down_q;
		res1.last_result   = 1'b1;
		two                = 1'b0;

		if (item.op == OP_EDGE) begin
			if (!bounce) begin
				res0.edge_accepted = 1'b1;
				res0.is_down       = pressed;
				last_edge_d        = item.time_us;
				down_d             = pressed;
				hold_done_d        = 1'b0;
				if (pressed) begin
					press_start_d = item.time_us;
					press_armed_d = 1'b1;
					long_done_d   = 1'b0;
				end else if (!long_done_q && short_press) begin
					release_time_d  = item.time_us;
					release_armed_d = 1'b1;
					if (clicks_inc >= 2'd2) begin
						res0.action = ACT_DOUBLE;
						clicks_d    = '0;
					end else begin
						clicks_d = clicks_inc;
					end
				end
			end
		end else begin
			if (fire_long) begin
				long_done_d = 1'b1;
				clicks_d    = '0;
			end
			if (fire_hold) begin
				hold_done_d = 1'b1;
				clicks_d    = '0;
			end
			if (fire_single)
				clicks_d = '0;
			if (fire_long && fire_hold) begin
				res0.action      = ACT_LONG;
				res0.last_result = 1'b0;
				two              = 1'b1;
			end else if (fire_long) begin
				res0.action = ACT_LONG;
			end else if (fire_hold) begin
				res0.action = ACT_RESET;
			end else if (fire_single) begin
				res0.action = ACT_SINGLE;
			end
		end
	end

	// commit control state as the item leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			down_q          <= 1'b0;
			press_armed_q   <= 1'b0;
			release_armed_q <= 1'b0;
			long_done_q     <= 1'b0;
			hold_done_q     <= 1'b0;
			clicks_q        <= '0;
			last_edge_q     <= '0;
			press_start_q   <= '0;
			release_time_q  <= '0;
		end else if (advance) begin
			down_q          <= down_d;
			press_armed_q   <= press_armed_d;
			release_armed_q <= release_armed_d;
			long_done_q     <= long_done_d;
			hold_done_q     <= hold_done_d;
			clicks_q        <= clicks_d;
			last_edge_q     <= last_edge_d;
			press_start_q   <= press_start_d;
			release_time_q  <= release_time_d;
		end
	end

endmodule

### rtl/core/bcc_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_out_stage
// Result register with one slot for the second result of an item.
// ----------------------------------------------------------------------------
module bcc_out_stage
	import bcc_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  bcc_result_t     res0,
	input  bcc_result_t     res1,
	input  logic            two,
	input  logic            out_stall,
	output bcc_result_t     out_res,
	output bcc_out_status_t status
);

	logic        valid_q, pend_q;
	bcc_result_t out_q, pend_res_q;
	logic        take;

	assign take         = valid_q && !out_stall;
	assign status.valid = valid_q;
	assign status.pend  = pend_q;
	assign status.free  = !valid_q || (take && !pend_q);
	assign out_res      = out_q;

	// control: load a new item, or advance the queued second result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			pend_q  <= two;
		end else if (take) begin
			valid_q <= pend_q;
			pend_q  <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_q      <= res0;
			pend_res_q <= res1;
		end else if (take && pend_q) begin
			out_q <= pend_res_q;
		end
	end

endmodule

### rtl/core/button_click_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_click_classifier
// Debounces an active-low button and reports single, double, long press and
// pairing-reset hold from edge and tick requests.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  in      | in_valid / in_stall    | operation, pin_level, time_us
//  out     | out_valid / out_stall  | action, edge_accepted, is_down, last_result
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  A request is held in the input register, is classified and lands in the
//  result register. One request per cycle while out_stall is low; a request
//  with two results holds the input while the second result drains from its slot.
//  out_stall backs up through the result register into in_stall.
//  Reset clears state and loads the default timing registers; cfg_ready is
//  always high.
// ----------------------------------------------------------------------------
module button_click_classifier
	import bcc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 operation,
	input  logic                 pin_level,
	input  logic [TIME_W-1:0]    time_us,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [ACT_W-1:0]     action,
	output logic                 edge_accepted,
	output logic                 is_down,
	output logic                 last_result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [MS_W-1:0]      cfg_data
);

	logic            valid_s1;
	bcc_item_t       item_s1;
	logic            accept, advance, two;
	bcc_thresh_t     thresh;
	bcc_result_t     res0, res1, out_res;
	bcc_out_status_t ostat;

	assign cfg_ready = 1'b1;
	assign in_stall  = valid_s1 && !ostat.free;
	assign accept    = in_valid && !in_stall;
	assign advance   = valid_s1 && ostat.free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (ostat.free) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.op      <= operation;
			item_s1.pin     <= pin_level;
			item_s1.time_us <= time_us;
		end
	end

	bcc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.thresh   (thresh)
	);

	bcc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.thresh  (thresh),
		.res0    (res0),
		.res1    (res1),
		.two     (two)
	);

	bcc_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.res0      (res0),
		.res1      (res1),
		.two       (two),
		.out_stall (out_stall),
		.out_res   (out_res),
		.status    (ostat)
	);

	assign out_valid     = ostat.valid;
	assign action        = out_res.action;
	assign edge_accepted = out_res.edge_accepted;
	assign is_down       = out_res.is_down;
	assign last_result   = out_res.last_result;

	// a queued second result always sits behind a shown one
	assert property (@(posedge clk) disable iff (!arst_n) ostat.pend |-> ostat.valid)
		else $error("second result queued with empty result register");

	// only a long press is followed by another result
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last_result) |-> (action == ACT_LONG))
		else $error("non-final result is not a long press");

	// an accepted edge reports nothing but a double click
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && edge_accepted) |-> (action == ACT_NONE || action == ACT_DOUBLE))
		else $error("edge result carries a tick action");

	// stall only while the input register is full
	assert property (@(posedge clk) disable iff (!arst_n) in_stall |-> valid_s1)
		else $error("input stalled with empty input register");

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for button_click_classifier. Edge and tick requests go
// in through the valid/stall port while a local classifier mirrors the
// debounce, click, long-press and pairing-hold logic. Every status request
// that comes out is compared field by field with the oldest predicted one.
// Directed cases cover power-on edges, repeated levels, time wrap and both
// register extremes; random gestures then run under several settings while
// the sender and receiver idle at changing rates.
// ----------------------------------------------------------------------------
module testbench;
	import bcc_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic                 operation;
	logic                 pin_level;
	logic [TIME_W-1:0]    time_us;
	logic                 out_valid;
	logic                 out_stall;
	logic [ACT_W-1:0]     action;
	logic                 edge_accepted;
	logic                 is_down;
	logic                 last_result;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [MS_W-1:0]      cfg_data;

	button_click_classifier u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.operation     (operation),
		.pin_level     (pin_level),
		.time_us       (time_us),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.action        (action),
		.edge_accepted (edge_accepted),
		.is_down       (is_down),
		.last_result   (last_result),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// classifier mirror: settings and button state
	logic [MS_W-1:0]   setting_ms [0:4];
	logic              btn_down;
	logic [TIME_W-1:0] last_edge_t;
	logic [TIME_W-1:0] press_t;
	logic [TIME_W-1:0] release_t;
	logic [CLK_W-1:0]  click_cnt;
	logic              long_fired;
	logic              hold_fired;
	logic              press_seen;
	logic              release_seen;

	bcc_result_t       expected_status [$];
	int                mismatches;
	int                requests_sent;
	int                send_idle_pct;
	int                stall_pct;
	logic [TIME_W-1:0] tnow;

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// receiver backpressure
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("button_click_classifier: mismatch");
		$finish;
	end

	task automatic flag_mismatch(input string msg);
		if (mismatches < 40)
			$display("%0t ns: %s", $time, msg);
		mismatches++;
	endtask

	function automatic logic [63:0] since_us(input logic [TIME_W-1:0] now,
			input logic [TIME_W-1:0] then);
		logic [TIME_W-1:0] d;
		d = now - then;
		return 64'(d);
	endfunction

	function automatic logic [63:0] limit_us(input logic [CFG_IDX_W-1:0] idx);
		return 64'(setting_ms[idx]) * 64'(US_PER_MS);
	endfunction

	task automatic clear_classifier();
		setting_ms[CFG_DEBOUNCE] = RST_DEBOUNCE_MS;
		setting_ms[CFG_SHORT]    = RST_SHORT_MS;
		setting_ms[CFG_DOUBLE]   = RST_DOUBLE_MS;
		setting_ms[CFG_LONG]     = RST_LONG_MS;
		setting_ms[CFG_HOLD]     = RST_HOLD_MS;
		btn_down     = 1'b0;
		last_edge_t  = '0;
		press_t      = '0;
		release_t    = '0;
		click_cnt    = '0;
		long_fired   = 1'b0;
		hold_fired   = 1'b0;
		press_seen   = 1'b0;
		release_seen = 1'b0;
	endtask

	function automatic bcc_result_t status(input logic [ACT_W-1:0] act,
			input logic acc, input logic last);
		bcc_result_t r;
		r.action        = act;
		r.edge_accepted = acc;
		r.is_down       = btn_down;
		r.last_result   = last;
		return r;
	endfunction

	// predict the status requests of one accepted request
	task automatic classify_request(input logic op, input logic pin,
			input logic [TIME_W-1:0] now);
		logic [ACT_W-1:0] acts [0:1];
		logic [ACT_W-1:0] act;
		int               n;
		n = 0;
		if (op == OP_EDGE) begin
			act = ACT_NONE;
			if (since_us(now, last_edge_t) < limit_us(CFG_DEBOUNCE)) begin
				// drop bounce inside the debounce window
				expected_status.push_back(status(ACT_NONE, 1'b0, 1'b1));
			end else begin
				last_edge_t = now;
				btn_down    = !pin;
				if (!pin) begin
					press_t    = now;
					press_seen = 1'b1;
					long_fired = 1'b0;
					hold_fired = 1'b0;
				end else begin
					hold_fired = 1'b0;
					if (!long_fired &&
							since_us(now, press_t) / 64'(US_PER_MS) <
							64'(setting_ms[CFG_SHORT])) begin
						if (click_cnt < 2'd3)
							click_cnt++;
						release_t    = now;
						release_seen = 1'b1;
						if (click_cnt >= 2'd2) begin
							act       = ACT_DOUBLE;
							click_cnt = '0;
						end
					end
				end
				expected_status.push_back(status(act, 1'b1, 1'b1));
			end
		end else begin
			// tick: long press first, then pairing hold, else an expired click
			if (btn_down && press_seen && !long_fired &&
					since_us(now, press_t) >= limit_us(CFG_LONG)) begin
				long_fired = 1'b1;
				click_cnt  = '0;
				acts[n]    = ACT_LONG;
				n++;
			end
			if (btn_down && press_seen && !hold_fired &&
					since_us(now, press_t) >= limit_us(CFG_HOLD)) begin
				hold_fired = 1'b1;
				click_cnt  = '0;
				acts[n]    = ACT_RESET;
				n++;
			end
			if (!btn_down && click_cnt == 2'd1 && release_seen && n < 2 &&
					since_us(now, release_t) >= limit_us(CFG_DOUBLE)) begin
				click_cnt = '0;
				acts[n]   = ACT_SINGLE;
				n++;
			end
			if (n == 0)
				expected_status.push_back(status(ACT_NONE, 1'b0, 1'b1));
			for (int k = 0; k < n; k++)
				expected_status.push_back(status(acts[k], 1'b0, k == n - 1));
		end
	endtask

	task automatic store_setting(input logic [CFG_IDX_W-1:0] idx,
			input logic [MS_W-1:0] data);
		case (idx)
			CFG_DEBOUNCE, CFG_SHORT, CFG_DOUBLE, CFG_LONG, CFG_HOLD: setting_ms[idx] = data;
			default: ;
		endcase
	endtask

	task automatic check_status();
		bcc_result_t want;
		if (expected_status.size() == 0) begin
			flag_mismatch($sformatf("status request with none expected, action %0d", action));
		end else begin
			want = expected_status.pop_front();
			if (action !== want.action)
				flag_mismatch($sformatf("action %0d, expected %0d", action, want.action));
			if (edge_accepted !== want.edge_accepted)
				flag_mismatch($sformatf("edge_accepted %0b, expected %0b",
					edge_accepted, want.edge_accepted));
			if (is_down !== want.is_down)
				flag_mismatch($sformatf("is_down %0b, expected %0b", is_down, want.is_down));
			if (last_result !== want.last_result)
				flag_mismatch($sformatf("last_result %0b, expected %0b",
					last_result, want.last_result));
		end
	endtask

	// watch all three channels at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				check_status();
			if (in_valid && !in_stall)
				classify_request(operation, pin_level, time_us);
			if (cfg_valid && cfg_ready)
				store_setting(cfg_index, cfg_data);
		end
	end

	// advance local time by gap and send one request
	task automatic send_item(input logic op, input logic pin,
			input logic [TIME_W-1:0] gap);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		tnow = tnow + gap;
		operation <= op;
		pin_level <= pin;
		time_us   <= tnow;
		in_valid  <= 1'b1;
		do @(posedge clk); while (in_stall);
		requests_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MS_W-1:0] data);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// hold the input low until every predicted status has come out
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_status.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// stimulus gaps scaled to the current settings
	function automatic int unsigned us_of(input logic [CFG_IDX_W-1:0] idx);
		return setting_ms[idx] * 1000;
	endfunction

	function automatic int unsigned about_us(input logic [CFG_IDX_W-1:0] idx);
		int unsigned b;
		int unsigned j;
		b = us_of(idx);
		j = $urandom_range(0, 4000);
		return (b + j > 2000) ? b + j - 2000 : 0;
	endfunction

	function automatic int unsigned upto_us(input logic [CFG_IDX_W-1:0] idx, input int div);
		return $urandom_range(0, us_of(idx) / div + 1000);
	endfunction

	function automatic int unsigned clear_debounce();
		return us_of(CFG_DEBOUNCE) + $urandom_range(0, 3000);
	endfunction

	function automatic int unsigned click_us();
		int unsigned lo;
		int unsigned hi;
		lo = us_of(CFG_DEBOUNCE);
		hi = us_of(CFG_SHORT);
		if (hi <= lo)
			hi = lo + 3000;
		return $urandom_range(hi, lo);
	endfunction

	function automatic logic [CFG_IDX_W-1:0] any_reg();
		return CFG_IDX_W'($urandom_range(CFG_HOLD, CFG_DEBOUNCE));
	endfunction

	function automatic logic [MS_W-1:0] pick_ms(input int lo, input int hi);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return MS_W'($urandom_range(hi, lo));
	endfunction

	// one gesture: mostly well-formed presses, some bounce and noise
	task automatic random_gesture();
		int kind;
		int n;
		kind = $urandom_range(0, 9);
		n    = $urandom_range(1, 4);
		case (kind)
			0, 1: begin
				// single click, then ticks across the double-click wait
				send_item(OP_EDGE, 1'b0, clear_debounce() + upto_us(CFG_DOUBLE, 1));
				send_item(OP_EDGE, 1'b1,
					$urandom_range(0, 3) == 0 ? about_us(CFG_SHORT) : click_us());
				repeat (n) send_item(OP_TICK, 1'($urandom_range(0, 1)),
					$urandom_range(0, 1) ? about_us(CFG_DOUBLE) : upto_us(CFG_DOUBLE, 2));
			end
			2, 3: begin
				// two clicks inside the double-click wait
				send_item(OP_EDGE, 1'b0, clear_debounce() + upto_us(CFG_DOUBLE, 1));
				send_item(OP_EDGE, 1'b1, click_us());
				send_item(OP_EDGE, 1'b0, clear_debounce() + upto_us(CFG_DOUBLE, 2));
				send_item(OP_EDGE, 1'b1, click_us());
				send_item(OP_TICK, 1'($urandom_range(0, 1)), about_us(CFG_DOUBLE));
			end
			4: begin
				// long press
				send_item(OP_EDGE, 1'b0, clear_debounce() + upto_us(CFG_DOUBLE, 1));
				repeat (n) send_item(OP_TICK, 1'($urandom_range(0, 1)),
					$urandom_range(0, 1) ? about_us(CFG_LONG) : upto_us(CFG_LONG, 2));
				send_item(OP_EDGE, 1'b1, clear_debounce());
			end
			5: begin
				// pairing hold
				send_item(OP_EDGE, 1'b0, clear_debounce());
				repeat (n + 1) send_item(OP_TICK, 1'($urandom_range(0, 1)),
					$urandom_range(0, 2) == 0 ? about_us(CFG_HOLD) : upto_us(CFG_HOLD, 3));
				send_item(OP_EDGE, 1'b1, $urandom_range(0, 1) ? clear_debounce() : 0);
			end
			6: begin
				// contact bounce around the debounce window
				repeat (n + 1) send_item(OP_EDGE, 1'($urandom_range(0, 1)),
					$urandom_range(0, us_of(CFG_DEBOUNCE) + 2000));
			end
			7: begin
				repeat (n) send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					$urandom_range(0, 1) ? about_us(any_reg()) : upto_us(any_reg(), 1));
			end
			8: begin
				// jump the clock anywhere, or just short of the wrap
				if ($urandom_range(0, 1))
					tnow = TIME_W'({$urandom(), $urandom()});
				else
					tnow = '1 - TIME_W'($urandom_range(0, us_of(CFG_LONG)));
				send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					about_us(any_reg()));
			end
			default: begin
				repeat (n) send_item(OP_TICK, 1'($urandom_range(0, 1)),
					upto_us(any_reg(), 2));
			end
		endcase
	endtask

	task automatic apply_reset();
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		operation = OP_EDGE;
		pin_level = 1'b1;
		time_us   = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_DEBOUNCE;
		cfg_data  = '0;
		tnow      = '0;
		clear_classifier();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	endtask

	// default settings: power-on edges, clicks, holds and time wrap
	task automatic test_default_gestures();
		send_item(OP_EDGE, 1'b0, 5000);       // inside window after time zero
		send_item(OP_TICK, 1'b1, 1000);       // nothing armed yet
		send_item(OP_TICK, 1'b0, 0);
		send_item(OP_EDGE, 1'b1, 19000);      // release with no press seen
		send_item(OP_TICK, 1'b1, 375000);     // single
		send_item(OP_EDGE, 1'b0, 600000);
		send_item(OP_EDGE, 1'b0, 100000);     // same level again
		send_item(OP_EDGE, 1'b1, 100000);
		send_item(OP_EDGE, 1'b0, 100000);
		send_item(OP_EDGE, 1'b1, 100000);     // double
		send_item(OP_EDGE, 1'b0, 600000);
		send_item(OP_TICK, 1'b1, 799999);     // one microsecond short of long
		send_item(OP_TICK, 1'b1, 1);          // long
		send_item(OP_EDGE, 1'b1, 100000);
		send_item(OP_EDGE, 1'b0, 1000000);
		send_item(OP_TICK, 1'b1, 11000000);   // long and pairing together
		send_item(OP_EDGE, 1'b1, 100000);
		// click across the time wrap
		tnow = '1 - TIME_W'(50000);
		send_item(OP_EDGE, 1'b0, 0);
		send_item(OP_EDGE, 1'b1, 100000);
		send_item(OP_TICK, 1'b0, 400000);
		tnow = '1;
		send_item(OP_EDGE, 1'b1, 0);
		send_item(OP_EDGE, 1'b0, 1);          // wraps to zero, dropped
		send_item(OP_TICK, 1'b1, 300000);
		wait_idle();
	endtask

	// every register at zero, then at full scale, then unknown indexes
	task automatic test_register_extremes();
		write_reg(CFG_DEBOUNCE, '0);
		write_reg(CFG_SHORT, '0);
		write_reg(CFG_DOUBLE, '0);
		write_reg(CFG_LONG, '0);
		write_reg(CFG_HOLD, '0);
		send_item(OP_EDGE, 1'b0, 0);
		send_item(OP_TICK, 1'b1, 0);
		send_item(OP_TICK, 1'b0, 0);
		send_item(OP_EDGE, 1'b1, 0);
		send_item(OP_EDGE, 1'b0, 0);
		send_item(OP_EDGE, 1'b1, 5000);
		send_item(OP_TICK, 1'b1, 0);
		wait_idle();
		write_reg(CFG_DEBOUNCE, '1);
		write_reg(CFG_SHORT, '1);
		write_reg(CFG_DOUBLE, '1);
		write_reg(CFG_LONG, '1);
		write_reg(CFG_HOLD, '1);
		send_item(OP_EDGE, 1'b0, 70000000);
		send_item(OP_TICK, 1'b1, 1000);
		send_item(OP_TICK, 1'b1, 66000000);
		send_item(OP_EDGE, 1'b1, 100);
		send_item(OP_EDGE, 1'b1, 66000000);
		send_item(OP_EDGE, 1'b0, 65535000);   // exactly on the window
		send_item(OP_EDGE, 1'b1, 65534999);
		wait_idle();
		write_reg(CFG_IDX_W'(CFG_HOLD + 1), '0);
		write_reg('1, '0);
		send_item(OP_EDGE, 1'b1, 1000);
		wait_idle();
	endtask

	task automatic load_random_settings();
		wait_idle();
		write_reg(CFG_DEBOUNCE, pick_ms(0, 40));
		write_reg(CFG_SHORT, pick_ms(50, 600));
		write_reg(CFG_DOUBLE, pick_ms(50, 500));
		write_reg(CFG_LONG, pick_ms(100, 1500));
		write_reg(CFG_HOLD, pick_ms(200, 4000));
		if ($urandom_range(0, 3) == 0)
			write_reg(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, CFG_HOLD + 1)),
				MS_W'($urandom()));
	endtask

	task automatic test_random_gestures(input int settings, input int per_setting);
		int stop_at;
		repeat (settings) begin
			load_random_settings();
			stop_at = requests_sent + per_setting;
			while (requests_sent < stop_at)
				random_gesture();
		end
		wait_idle();
	endtask

	initial begin
		mismatches    = 0;
		requests_sent = 0;
		send_idle_pct = 20;
		stall_pct     = 76;
		apply_reset();
		test_default_gestures();
		test_register_extremes();
		test_random_gestures(4, 75);
		send_idle_pct = 76;
		stall_pct     = 20;
		test_random_gestures(4, 75);
		send_idle_pct = 0;
		stall_pct     = 0;
		test_random_gestures(4, 75);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("button_click_classifier: match");
		else
			$display("button_click_classifier: mismatch");
		$finish;
	end

endmodule
